// ----- hw/rtl/srr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Selective-repeat receiver package
// Shared constants, command codes and the types that pass between the
// front end, the execution back end and the result queue.
// ---------------------------------------------------------------------------
package srr_pkg;

	// Window and data sizes.
	localparam int WINDOW       = 8;
	localparam int SLOT_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PAYLOAD_BITS = 64;
	localparam int ID_BITS      = 16;
	localparam int OP_BITS      = 2;
	localparam int DATA_BITS    = 64;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [CFG_DATA_BITS-1:0]  TOTAL_RESET   = 16'd853;
	localparam logic [CFG_DATA_BITS-1:0]  TIMEOUT_RESET = 16'd550;

	// Input operation codes.
	localparam logic [OP_BITS-1:0] OP_START = 2'd0;
	localparam logic [OP_BITS-1:0] OP_MSG   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_TICK  = 2'd2;

	// Command kinds passed to the back end.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_MSG   = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Queue depths.
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	// One classified request from the front end.
	typedef struct packed {
		logic [1:0]              kind;
		logic [ID_BITS-1:0]      id;
		logic [PAYLOAD_BITS-1:0] data;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic                    deliver_valid;
		logic [PAYLOAD_BITS-1:0] data;
		logic                    request_valid;
		logic [ID_BITS-1:0]      request_id;
		logic                    done_res;
		logic                    last;
	} res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/srr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Selective-repeat receiver front end
// Accepts input items, decodes the operation into a command and holds it
// in a short queue until the back end takes it.
// ---------------------------------------------------------------------------
module srr_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [srr_pkg::OP_BITS-1:0]       op,
	input  wire logic [srr_pkg::ID_BITS-1:0]       msg_id,
	input  wire logic [srr_pkg::DATA_BITS-1:0]     payload,
	output logic                                   cmd_valid,
	output srr_pkg::cmd_t                          cmd,
	input  wire logic                              cmd_pop
);

	localparam int PTR_BITS = (srr_pkg::CMD_DEPTH > 1) ? $clog2(srr_pkg::CMD_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(srr_pkg::CMD_DEPTH + 1);

	srr_pkg::cmd_t         entry_q [srr_pkg::CMD_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  accept;
	logic                  known_op;
	logic                  enq;
	logic                  deq;
	srr_pkg::cmd_t         new_cmd;

	// Decode the operation; an unused code is accepted and dropped.
	always_comb begin
		known_op     = 1'b1;
		new_cmd.kind = srr_pkg::CMD_START;
		unique case (op)
			srr_pkg::OP_START: new_cmd.kind = srr_pkg::CMD_START;
			srr_pkg::OP_MSG:   new_cmd.kind = srr_pkg::CMD_MSG;
			srr_pkg::OP_TICK:  new_cmd.kind = srr_pkg::CMD_TICK;
			default:           known_op = 1'b0;
		endcase
		new_cmd.id   = msg_id;
		new_cmd.data = payload[srr_pkg::PAYLOAD_BITS-1:0];
	end

	assign full      = (count_q == CNT_BITS'(srr_pkg::CMD_DEPTH));
	assign accept    = push && !full;
	assign enq       = accept && known_op;
	assign cmd_valid = (count_q != '0);
	assign deq       = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(srr_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(srr_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (!enq && deq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/srr_result_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Selective-repeat receiver result queue
// Holds finished results so the back end keeps working while the
// consumer stalls.
// ---------------------------------------------------------------------------
module srr_result_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_push,
	input  wire srr_pkg::res_t res_in,
	output logic               res_full,
	output logic               empty,
	input  wire logic          pop,
	output srr_pkg::res_t      res_out
);

	localparam int PTR_BITS = (srr_pkg::RES_DEPTH > 1) ? $clog2(srr_pkg::RES_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(srr_pkg::RES_DEPTH + 1);

	srr_pkg::res_t         entry_q [srr_pkg::RES_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  enq;
	logic                  deq;

	assign res_full = (count_q == CNT_BITS'(srr_pkg::RES_DEPTH));
	assign empty    = (count_q == '0);
	assign enq      = res_push && !res_full;
	assign deq      = pop && !empty;
	assign res_out  = entry_q[rd_ptr_q];

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(srr_pkg::RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(srr_pkg::RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (!enq && deq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= res_in;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/srr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Selective-repeat receiver back end
// Holds the window state and the configuration registers, and carries out
// commands: start requests, message buffering with in-order draining, and
// idle timeouts. One result is produced per cycle at most.
// ---------------------------------------------------------------------------
module srr_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [srr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [srr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                cmd_valid,
	input  wire srr_pkg::cmd_t                       cmd,
	output logic                                     cmd_pop,
	input  wire logic                                res_full,
	output logic                                     res_push,
	output srr_pkg::res_t                            res
);

	localparam int W  = srr_pkg::WINDOW;
	localparam int SB = srr_pkg::SLOT_BITS;
	localparam int IB = srr_pkg::ID_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                       state_q, state_d;
	logic [IB-1:0]                    base_q, base_d;
	logic [SB-1:0]                    head_q, head_d;
	logic [IB-1:0]                    timer_q, timer_d;
	logic                             finished_q, finished_d;
	logic [W-1:0]                     valid_q, valid_d;
	logic [SB-1:0]                    cnt_q, cnt_d;
	logic [srr_pkg::CFG_DATA_BITS-1:0] total_q;
	logic [srr_pkg::CFG_DATA_BITS-1:0] timeout_q;
	logic [srr_pkg::PAYLOAD_BITS-1:0] slot_data_q [W];

	logic                             wr_en;
	logic [SB-1:0]                    wr_slot;
	logic                             in_window;
	logic [IB-1:0]                    offset;
	logic [SB:0]                      msg_sum;
	logic [SB-1:0]                    msg_slot;
	logic [IB-1:0]                    base_inc;
	logic [SB-1:0]                    head_inc;
	logic [IB:0]                      req_next;
	logic                             req_ok;
	logic                             drain_done;
	logic [IB-1:0]                    timer_inc;

	// Window check and slot position of an arriving message.
	assign in_window = (cmd.id >= base_q) &&
		({1'b0, cmd.id} < ({1'b0, base_q} + (IB+1)'(W)));
	assign offset    = cmd.id - base_q;
	assign msg_sum   = {1'b0, head_q} + {1'b0, offset[SB-1:0]};
	assign msg_slot  = (msg_sum >= (SB+1)'(W)) ? SB'(msg_sum - (SB+1)'(W)) : msg_sum[SB-1:0];

	// Base advance, request id and completion test for one delivery.
	assign base_inc   = base_q + 1'b1;
	assign head_inc   = (base_q == '1) ? '0 :
		((head_q == SB'(W - 1)) ? '0 : head_q + 1'b1);
	assign req_next   = {1'b0, base_inc} + (IB+1)'(W - 1);
	assign req_ok     = (req_next < {1'b0, total_q});
	assign drain_done = (base_inc >= total_q);

	// Saturating idle timer.
	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;

	// Command sequencer.
	always_comb begin
		state_d    = state_q;
		base_d     = base_q;
		head_d     = head_q;
		timer_d    = timer_q;
		finished_d = finished_q;
		valid_d    = valid_q;
		cnt_d      = cnt_q;
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		wr_en      = 1'b0;
		wr_slot    = msg_slot;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						srr_pkg::CMD_START: begin
							base_d     = '0;
							head_d     = '0;
							timer_d    = '0;
							finished_d = 1'b0;
							valid_d    = '0;
							cnt_d      = '0;
							state_d    = ST_START;
						end
						srr_pkg::CMD_MSG: begin
							if (!finished_q && in_window) begin
								wr_en             = 1'b1;
								valid_d[msg_slot] = 1'b1;
								state_d           = ST_DRAIN;
							end
						end
						srr_pkg::CMD_TICK: begin
							if (!finished_q) begin
								if (timer_inc > timeout_q) begin
									timer_d            = '0;
									res_push           = 1'b1;
									res.request_valid  = 1'b1;
									res.request_id     = base_q;
									res.last           = 1'b1;
								end else begin
									timer_d = timer_inc;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_START: begin
				// First window of ids: one request per cycle while res_full is low.
				if (!res_full) begin
					res_push          = 1'b1;
					res.request_valid = 1'b1;
					res.request_id    = IB'(cnt_q);
					res.last          = (cnt_q == SB'(W - 1));
					cnt_d             = cnt_q + 1'b1;
					if (cnt_q == SB'(W - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DRAIN: begin
				// Deliver the slot at the base while it holds data.
				if (!valid_q[head_q]) begin
					state_d = ST_IDLE;
				end else if (!res_full) begin
					res_push          = 1'b1;
					res.deliver_valid = 1'b1;
					res.data          = slot_data_q[head_q];
					res.request_valid = req_ok;
					res.request_id    = req_ok ? req_next[IB-1:0] : '0;
					res.done_res      = drain_done;
					res.last          = drain_done || !valid_q[head_inc];
					valid_d[head_q]   = 1'b0;
					timer_d           = '0;
					base_d            = base_inc;
					head_d            = head_inc;
					if (drain_done) begin
						finished_d = 1'b1;
					end
					if (drain_done || !valid_q[head_inc]) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_q     <= '0;
			head_q     <= '0;
			timer_q    <= '0;
			finished_q <= 1'b0;
			valid_q    <= '0;
			cnt_q      <= '0;
		end else begin
			state_q    <= state_d;
			base_q     <= base_d;
			head_q     <= head_d;
			timer_q    <= timer_d;
			finished_q <= finished_d;
			valid_q    <= valid_d;
			cnt_q      <= cnt_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= srr_pkg::TOTAL_RESET;
			timeout_q <= srr_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srr_pkg::REG_TOTAL:   total_q   <= cfg_data;
				srr_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Slot payload storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_data_q[wr_slot] <= cmd.data;
		end
	end

	// A result is never pushed into a full queue.
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed while result queue full");

	// Deliveries come only from the drain sequence.
	a_deliver_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.deliver_valid) |-> (state_q == ST_DRAIN))
		else $error("delivery outside drain");

	// The transfer completes only through a delivery marked done.
	a_finish_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(finished_q) |-> $past(res_push && res.done_res))
		else $error("finished set without a done delivery");

	// A new command is taken only when the sequencer is idle.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE && cmd_valid))
		else $error("command taken while busy");

	// After the last start request the sequencer returns to idle.
	a_start_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START && res_push && res.last) |=> (state_q == ST_IDLE))
		else $error("start sequence did not end");

endmodule
`default_nettype wire

// ----- hw/rtl/selective_repeat_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Selective-repeat receiver
// Receiver side of a selective-repeat ARQ link with an eight-slot window.
// ---------------------------------------------------------------------------
// Usage:
//   Input items enter through push/full; op selects start, message or tick.
//   Results leave through empty/pop; each carries a delivery, a request for
//   the sender, or both, and last marks the final result of its item.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and the user must make them only while the block is idle (unchecked).
// Flow:
//   An accepted item waits in the command queue until the back end is idle
//   and the result queue has room. A tick's result, if any, is pushed when
//   the tick is taken; the first result of a start or a kept message comes
//   from the start or drain state entered after it is taken. The sequencer
//   produces at most one result per cycle: a start gives one request per
//   slot of the first window, a kept message one delivery per slot drained.
//   A two-entry command queue keeps accepting while the sequencer works.
// Reset:
//   Clears the window, timer and finished flag, and loads the default
//   message total and timeout. No clearing pass is needed.
// Stalls:
//   When the result queue fills, the sequencer waits; the command queue
//   then fills and full rises. Nothing is lost.
// ---------------------------------------------------------------------------
module selective_repeat_receiver (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [srr_pkg::OP_BITS-1:0]         op,
	input  wire logic [srr_pkg::ID_BITS-1:0]         msg_id,
	input  wire logic [srr_pkg::DATA_BITS-1:0]       payload,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic                                     deliver_valid,
	output logic [srr_pkg::DATA_BITS-1:0]            delivered_data,
	output logic                                     request_valid,
	output logic [srr_pkg::ID_BITS-1:0]              request_id,
	output logic                                     done_res,
	output logic                                     last,
	input  wire logic                                cfg_we,
	input  wire logic [srr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [srr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	logic           cmd_valid;
	srr_pkg::cmd_t  cmd;
	logic           cmd_pop;
	logic           res_full;
	logic           res_push;
	srr_pkg::res_t  res_in;
	srr_pkg::res_t  res_out;

	// Front end: accept and classify.
	srr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.msg_id    (msg_id),
		.payload   (payload),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: window state and result generation.
	srr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue toward the consumer.
	srr_result_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	// Result fields onto the ports.
	assign deliver_valid  = res_out.deliver_valid;
	assign delivered_data = srr_pkg::DATA_BITS'(res_out.data);
	assign request_valid  = res_out.request_valid;
	assign request_id     = res_out.request_id;
	assign done_res       = res_out.done_res;
	assign last           = res_out.last;

endmodule
`default_nettype wire
